// ----- sv/ffsi_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsi_pkg
// Shared types and constants for the FIFO with fourth-slot insert.
// ----------------------------------------------------------------------------
package ffsi_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int INSERT_SLOT = 3;
    localparam int INSERT_MIN  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_INSERT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_LOAD = 2'd1,
        SEL_PREV = 2'd2,
        SEL_NEXT = 2'd3
    } sel_t;

endpackage

// ----- sv/ffsi_req_if.sv -----
// ----------------------------------------------------------------------------
// ffsi_req_if
// Request channel: one operation and its data word per beat.
// ----------------------------------------------------------------------------
interface ffsi_req_if
    import ffsi_pkg::*;
();

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

// ----- sv/ffsi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ffsi_rsp_if
// Response channel: status, popped word, empty flag and count per beat.
// ----------------------------------------------------------------------------
interface ffsi_rsp_if
    import ffsi_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped_value;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output popped_value,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input is_empty, input entry_count, output ready);

endinterface

// ----- sv/ffsi_cell.sv -----
// ----------------------------------------------------------------------------
// ffsi_cell
// One queue entry: holds its word, loads a new one, or takes a neighbor's.
// ----------------------------------------------------------------------------
module ffsi_cell
    import ffsi_pkg::*;
(
    input  logic                  clk,
    input  sel_t                  sel,
    input  logic [DATA_WIDTH-1:0] load_data,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        unique case (sel)
            SEL_HOLD: data_next = data_reg;
            SEL_LOAD: data_next = load_data;
            SEL_PREV: data_next = prev_data;
            SEL_NEXT: data_next = next_data;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/fifo_with_fourth_slot_insert_top.sv -----
// ----------------------------------------------------------------------------
// fifo_with_fourth_slot_insert_top
// Bounded FIFO built from a row of entry cells, with push, pop, clear and
// an insert that places the word as the fourth entry, or at the tail when fewer than four are held.
//
//   Channel  Direction  Beat contents
//   req      sink       operation, value
//   rsp      source     status, popped_value, is_empty, entry_count
//
// The response is registered and appears in the cycle after the request
// beat. A new request is taken in every cycle while the response register is
// empty or being drained. Reset clears the entry count and the response
// valid; the entry words are not reset.
// ----------------------------------------------------------------------------
module fifo_with_fourth_slot_insert_top
    import ffsi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ffsi_req_if.sink   req,
    ffsi_rsp_if.source rsp
);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    status_t               status_reg;
    status_t               status_next;
    logic [VALUE_W-1:0]    popped_reg;
    logic [VALUE_W-1:0]    popped_next;

    logic                  accept;
    op_t                   op;
    logic                  full;
    logic [DATA_WIDTH-1:0] word;
    sel_t                  sel [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = op_t'(req.operation);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign word      = DATA_WIDTH'(req.value);

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        popped_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel[i] = SEL_HOLD;
        end
        unique case (op)
            OP_PUSH, OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (op == OP_INSERT && count_reg >= CNT_W'(INSERT_MIN))
                        begin
                            if (i == INSERT_SLOT)
                            begin
                                sel[i] = SEL_LOAD;
                            end
                            else if (i > INSERT_SLOT && CNT_W'(i) <= count_reg)
                            begin
                                sel[i] = SEL_PREV;
                            end
                        end
                        else if (CNT_W'(i) == count_reg)
                        begin
                            sel[i] = SEL_LOAD;
                        end
                    end
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    popped_next = VALUE_W'(cell_data[0]);
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        sel[i] = SEL_NEXT;
                    end
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (!accept)
        begin
            count_next = count_reg;
            for (int i = 0; i < DEPTH; i++)
            begin
                sel[i] = SEL_HOLD;
            end
        end
    end

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] prev_data;
            logic [DATA_WIDTH-1:0] next_data;

            if (g == 0)
            begin : g_first
                assign prev_data = word;
            end
            else
            begin : g_mid_prev
                assign prev_data = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign next_data = cell_data[g];
            end
            else
            begin : g_mid_next
                assign next_data = cell_data[g+1];
            end

            ffsi_cell u_cell (
                .clk       (clk),
                .sel       (sel[g]),
                .load_data (word),
                .prev_data (prev_data),
                .next_data (next_data),
                .data      (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.is_empty     = (count_reg == '0);
    assign rsp.entry_count  = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_POP && count_reg == '0)
        |=> (rsp.valid && rsp.status == ST_EMPTY && rsp.popped_value == '0))
        else $error("Pop on an empty queue did not report empty.");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_PUSH || op == OP_INSERT) && full)
        |=> (rsp.status == ST_FULL && count_reg == CNT_W'(DEPTH)))
        else $error("Push on a full queue was not refused.");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CLEAR) |=> (count_reg == '0 && rsp.is_empty))
        else $error("Clear did not empty the queue.");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("Entry count changed without a request beat.");

endmodule
